// ----- src/sgrpf_pkg.sv -----
// ----------------------------------------------------------------------------
// sgrpf_pkg
// Shared types and constants for the self-guided projection fit block.
// ----------------------------------------------------------------------------
package sgrpf_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int FILT_W      = 18;
   localparam int SUM_W       = 64;
   localparam int HALF_W      = 32;
   localparam int MAG_W       = 128;   // magnitude of a 64x64 product or a difference
   localparam int WIDE_W      = 130;   // signed det / numerator
   localparam int COEFF_W     = 32;
   localparam int IN_DATA_W   = 64;
   localparam int OUT_DATA_W  = 64;
   localparam int ILL_SCALE   = 100000000;
   localparam int ILL_SCALE_W = 27;
   localparam int LAST_PRODUCT = 5;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_ON  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_ON = 1'd1;

   localparam int OP_W = 4;
   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_IDLE   = 4'd0;
   localparam op_type OP_PREP   = 4'd1;
   localparam op_type OP_MLOAD  = 4'd2;
   localparam op_type OP_MPP    = 4'd3;
   localparam op_type OP_MSTORE = 4'd4;
   localparam op_type OP_ILL0   = 4'd5;
   localparam op_type OP_ILL1   = 4'd6;
   localparam op_type OP_DLOAD  = 4'd7;
   localparam op_type OP_DSTEP  = 4'd8;
   localparam op_type OP_ROUND  = 4'd9;
   localparam op_type OP_SAT    = 4'd10;
   localparam op_type OP_EMIT   = 4'd11;

   typedef struct packed {
      op_type     op;
      logic [2:0] sel;    // product index during the multiply phase
      logic [1:0] part;   // 32x32 partial product index
      logic       dsel;   // which coefficient the divider works on
   } cmd_type;

   typedef struct packed {
      logic pipe_busy;
      logic first_on;
      logic second_on;
      logic bad;
      logic out_busy;
   } status_type;

endpackage

// ----- src/sgrpf_datapath.sv -----
// ----------------------------------------------------------------------------
// sgrpf_datapath
// Pixel MAC pipeline, sequential 64x64 multiplier, ill-posed test,
// restoring divider with round-half-even and saturation, result register.
// ----------------------------------------------------------------------------
module sgrpf_datapath #(
   parameter int RESTORE_FRAC_BITS = 4,
   parameter int PROJ_FRAC_BITS    = 7,
   parameter int MAX_PIXELS        = 1048576
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_accept,
   input  logic [sgrpf_pkg::SAMPLE_W-1:0]        source_sample,
   input  logic [sgrpf_pkg::SAMPLE_W-1:0]        degraded_sample,
   input  logic signed [sgrpf_pkg::FILT_W-1:0]   filtered_a,
   input  logic signed [sgrpf_pkg::FILT_W-1:0]   filtered_b,
   input  logic                                  first_on,
   input  logic                                  second_on,
   input  sgrpf_pkg::cmd_type                    cmd,
   output sgrpf_pkg::status_type                 status,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic signed [sgrpf_pkg::COEFF_W-1:0]  coeff_first,
   output logic signed [sgrpf_pkg::COEFF_W-1:0]  coeff_second,
   output logic                                  ill_posed
);
   import sgrpf_pkg::*;

   localparam int R    = RESTORE_FRAC_BITS;
   localparam int FW   = ((FILT_W > SAMPLE_W + R + 1) ? FILT_W : SAMPLE_W + R + 1) + 1;
   localparam int SW   = SAMPLE_W + R + 2;
   localparam int PW   = 2 * FW;
   localparam int CW   = $clog2(MAX_PIXELS + 1);
   localparam int BW   = 2 * CW;
   localparam int KB   = (BW > ILL_SCALE_W) ? BW - ILL_SCALE_W + 1 : 1;
   localparam int SMW  = KB + ILL_SCALE_W;
   localparam int CMPW = (SMW > BW) ? SMW : BW;
   localparam int NUMW = MAG_W + PROJ_FRAC_BITS;

   // ---------------- pixel pipeline ----------------
   logic signed [FW-1:0] u_f, fa_in, fb_in, fa_ff, fb_ff;
   logic signed [SW-1:0] u_s, src_s, s_in, s_ff;
   logic                 v1_ff, v2_ff;
   logic signed [PW-1:0] paa_in, pbb_in, pab_in, pas_in, pbs_in;
   logic signed [PW-1:0] paa_ff, pbb_ff, pab_ff, pas_ff, pbs_ff;
   logic [SUM_W-1:0]     saa_ff, sbb_ff, sab_ff, sas_ff, sbs_ff;
   logic [CW-1:0]        cnt_ff;

   assign u_f   = FW'(degraded_sample) << R;
   assign u_s   = SW'(degraded_sample) << R;
   assign src_s = SW'(source_sample) << R;
   assign s_in  = src_s - u_s;
   assign fa_in = first_on  ? (FW'(filtered_a) - u_f) : '0;
   assign fb_in = second_on ? (FW'(filtered_b) - u_f) : '0;

   assign paa_in = fa_ff * fa_ff;
   assign pbb_in = fb_ff * fb_ff;
   assign pab_in = fa_ff * fb_ff;
   assign pas_in = fa_ff * s_ff;
   assign pbs_in = fb_ff * s_ff;

   always_ff @(posedge clock) begin
      fa_ff  <= fa_in;
      fb_ff  <= fb_in;
      s_ff   <= s_in;
      paa_ff <= paa_in;
      pbb_ff <= pbb_in;
      pab_ff <= pab_in;
      pas_ff <= pas_in;
      pbs_ff <= pbs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         saa_ff <= '0;
         sbb_ff <= '0;
         sab_ff <= '0;
         sas_ff <= '0;
         sbs_ff <= '0;
         cnt_ff <= '0;
      end else begin
         v1_ff <= in_accept;
         v2_ff <= v1_ff;
         if (cmd.op == OP_EMIT) begin
            saa_ff <= '0;
            sbb_ff <= '0;
            sab_ff <= '0;
            sas_ff <= '0;
            sbs_ff <= '0;
            cnt_ff <= '0;
         end else begin
            if (v2_ff) begin
               saa_ff <= saa_ff + SUM_W'(paa_ff);
               sbb_ff <= sbb_ff + SUM_W'(pbb_ff);
               sab_ff <= sab_ff + SUM_W'(pab_ff);
               sas_ff <= sas_ff + SUM_W'(pas_ff);
               sbs_ff <= sbs_ff + SUM_W'(pbs_ff);
            end
            if (in_accept && (cnt_ff < CW'(MAX_PIXELS)))
               cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // ---------------- 64x64 multiplier, one partial product a cycle ----------------
   logic [SUM_W-1:0]         a_op, b_op, ma_ff, mb_ff;
   logic                     msign_ff;
   logic [2*HALF_W-1:0]      pp_ff;
   logic                     ppv_ff;
   logic [1:0]               sh_ff;
   logic [MAG_W-1:0]         acc_ff;
   logic [HALF_W-1:0]        ha, hb;
   logic signed [WIDE_W-1:0] prod, t1_ff, det_ff, num0_ff, num1_ff;

   always_comb begin
      case (cmd.sel)
         3'd0:    begin a_op = saa_ff; b_op = sbb_ff; end
         3'd1:    begin a_op = sab_ff; b_op = sab_ff; end
         3'd2:    begin a_op = sbb_ff; b_op = sas_ff; end
         3'd3:    begin a_op = sab_ff; b_op = sbs_ff; end
         3'd4:    begin a_op = saa_ff; b_op = sbs_ff; end
         default: begin a_op = sab_ff; b_op = sas_ff; end
      endcase
   end

   assign ha   = cmd.part[1] ? ma_ff[SUM_W-1:HALF_W] : ma_ff[HALF_W-1:0];
   assign hb   = cmd.part[0] ? mb_ff[SUM_W-1:HALF_W] : mb_ff[HALF_W-1:0];
   assign prod = msign_ff ? -$signed(WIDE_W'(acc_ff)) : $signed(WIDE_W'(acc_ff));

   // ---------------- ill-posed test and divider ----------------
   logic [SMW-1:0]           small_ff;
   logic                     big_ff, dneg_ff, bad_ff;
   logic                     detneg_ff;
   logic [BW-1:0]            bound_ff;
   logic [NUMW-1:0]          q_ff;
   logic [MAG_W-1:0]         rem_ff, den;
   logic [MAG_W:0]           rem_sh, r2;
   logic signed [WIDE_W-1:0] dn, dmag;
   logic                     up, qbig;
   logic [COEFF_W-1:0]       lim, mag32;
   logic signed [COEFF_W-1:0] c0_ff, c1_ff, cval;
   logic                     both_on;

   assign both_on = first_on && second_on;
   assign den     = det_ff[MAG_W-1:0];
   assign rem_sh  = {rem_ff, q_ff[NUMW-1]};
   assign r2      = {rem_ff, 1'b0};
   assign up      = (r2 > {1'b0, den}) || ((r2 == {1'b0, den}) && q_ff[0]);
   assign dn      = cmd.dsel ? num1_ff : num0_ff;
   assign dmag    = dn[WIDE_W-1] ? -dn : dn;
   assign qbig    = |q_ff[NUMW-1:COEFF_W];
   assign lim     = dneg_ff ? {1'b1, {(COEFF_W-1){1'b0}}} : {1'b0, {(COEFF_W-1){1'b1}}};
   assign mag32   = (qbig || (q_ff[COEFF_W-1:0] > lim)) ? lim : q_ff[COEFF_W-1:0];
   assign cval    = dneg_ff ? -$signed(mag32) : $signed(mag32);

   always_ff @(posedge clock) begin
      if (reset) begin
         ppv_ff <= 1'b0;
      end else begin
         ppv_ff <= (cmd.op == OP_MPP);
      end
   end

   always_ff @(posedge clock) begin
      if (ppv_ff)
         acc_ff <= acc_ff + (MAG_W'(pp_ff) << (HALF_W * sh_ff));
      case (cmd.op)
         OP_PREP: begin
            c0_ff <= '0;
            c1_ff <= '0;
            if (!both_on) begin
               det_ff <= first_on ? WIDE_W'($signed(saa_ff)) : WIDE_W'($signed(sbb_ff));
               num0_ff <= WIDE_W'($signed(sas_ff));
               num1_ff <= WIDE_W'($signed(sbs_ff));
            end
         end
         OP_MLOAD: begin
            ma_ff    <= a_op[SUM_W-1] ? -a_op : a_op;
            mb_ff    <= b_op[SUM_W-1] ? -b_op : b_op;
            msign_ff <= a_op[SUM_W-1] ^ b_op[SUM_W-1];
            acc_ff   <= '0;
         end
         OP_MPP: begin
            pp_ff <= ha * hb;
            sh_ff <= 2'(cmd.part[1]) + 2'(cmd.part[0]);
         end
         OP_MSTORE: begin
            if (!cmd.sel[0])
               t1_ff <= prod;
            else begin
               case (cmd.sel[2:1])
                  2'd0:    det_ff  <= t1_ff - prod;
                  2'd1:    num0_ff <= t1_ff - prod;
                  default: num1_ff <= t1_ff - prod;
               endcase
            end
         end
         OP_ILL0: begin
            small_ff  <= det_ff[KB-1:0] * ILL_SCALE_W'(ILL_SCALE);
            big_ff    <= |det_ff[WIDE_W-1:KB];
            detneg_ff <= det_ff[WIDE_W-1];
            bound_ff  <= both_on ? BW'(cnt_ff) * BW'(cnt_ff) : BW'(cnt_ff);
         end
         OP_ILL1: begin
            bad_ff <= detneg_ff || (!big_ff && (CMPW'(small_ff) < CMPW'(bound_ff)));
         end
         OP_DLOAD: begin
            dneg_ff <= dn[WIDE_W-1];
            q_ff    <= NUMW'(dmag[MAG_W-1:0]) << PROJ_FRAC_BITS;
            rem_ff  <= '0;
         end
         OP_DSTEP: begin
            if (rem_sh >= {1'b0, den}) begin
               rem_ff <= MAG_W'(rem_sh - {1'b0, den});
               q_ff   <= {q_ff[NUMW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh[MAG_W-1:0];
               q_ff   <= {q_ff[NUMW-2:0], 1'b0};
            end
         end
         OP_ROUND: begin
            q_ff <= q_ff + NUMW'(up);
         end
         OP_SAT: begin
            if (cmd.dsel)
               c1_ff <= cval;
            else
               c0_ff <= cval;
         end
         default: begin
         end
      endcase
   end

   // ---------------- result register ----------------
   logic rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rv_ff <= 1'b1;
      end else if (rsp_tready) begin
         rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         coeff_first  <= c0_ff;
         coeff_second <= c1_ff;
         ill_posed    <= bad_ff;
      end
   end

   assign rsp_tvalid       = rv_ff;
   assign status.pipe_busy = v1_ff || v2_ff;
   assign status.first_on  = first_on;
   assign status.second_on = second_on;
   assign status.bad       = bad_ff;
   assign status.out_busy  = rv_ff && !rsp_tready;

endmodule

// ----- src/sgrpf_ctrl.sv -----
// ----------------------------------------------------------------------------
// sgrpf_ctrl
// Sequencer: accumulate, drain, six wide products when both filters are on, ill-posed test,
// up to two divisions, then hand the result to the output register.
// ----------------------------------------------------------------------------
module sgrpf_ctrl #(
   parameter int PROJ_FRAC_BITS = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tlast,
   output logic                  req_tready,
   input  sgrpf_pkg::status_type status,
   output sgrpf_pkg::cmd_type    cmd
);
   import sgrpf_pkg::*;

   localparam int NUMW = MAG_W + PROJ_FRAC_BITS;
   localparam int STW  = $clog2(NUMW);

   localparam logic [3:0] ST_ACC    = 4'd0;
   localparam logic [3:0] ST_DRAIN  = 4'd1;
   localparam logic [3:0] ST_PREP   = 4'd2;
   localparam logic [3:0] ST_MLOAD  = 4'd3;
   localparam logic [3:0] ST_MPP    = 4'd4;
   localparam logic [3:0] ST_MWAIT  = 4'd5;
   localparam logic [3:0] ST_MSTORE = 4'd6;
   localparam logic [3:0] ST_ILL0   = 4'd7;
   localparam logic [3:0] ST_ILL1   = 4'd8;
   localparam logic [3:0] ST_BRANCH = 4'd9;
   localparam logic [3:0] ST_DLOAD  = 4'd10;
   localparam logic [3:0] ST_DSTEP  = 4'd11;
   localparam logic [3:0] ST_ROUND  = 4'd12;
   localparam logic [3:0] ST_SAT    = 4'd13;
   localparam logic [3:0] ST_DONE   = 4'd14;

   logic [3:0]     state_ff, state_in;
   logic [2:0]     sel_ff, sel_in;
   logic [1:0]     part_ff, part_in;
   logic           dsel_ff, dsel_in;
   logic [STW-1:0] step_ff, step_in;
   logic           both_on;

   assign both_on    = status.first_on && status.second_on;
   assign req_tready = (state_ff == ST_ACC);

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      part_in  = part_ff;
      dsel_in  = dsel_ff;
      step_in  = step_ff;
      cmd.op   = OP_IDLE;
      cmd.sel  = sel_ff;
      cmd.part = part_ff;
      cmd.dsel = dsel_ff;
      case (state_ff)
         ST_ACC: begin
            if (req_tvalid && req_tlast)
               state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!status.pipe_busy)
               state_in = ST_PREP;
         end
         ST_PREP: begin
            cmd.op = OP_PREP;
            sel_in = '0;
            state_in = both_on ? ST_MLOAD : ST_ILL0;
         end
         ST_MLOAD: begin
            cmd.op   = OP_MLOAD;
            part_in  = '0;
            state_in = ST_MPP;
         end
         ST_MPP: begin
            cmd.op  = OP_MPP;
            part_in = part_ff + 1'b1;
            if (part_ff == 2'd3)
               state_in = ST_MWAIT;
         end
         ST_MWAIT: begin
            state_in = ST_MSTORE;   // last partial product lands in the accumulator
         end
         ST_MSTORE: begin
            cmd.op = OP_MSTORE;
            if (sel_ff == 3'(LAST_PRODUCT))
               state_in = ST_ILL0;
            else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_MLOAD;
            end
         end
         ST_ILL0: begin
            cmd.op   = OP_ILL0;
            state_in = ST_ILL1;
         end
         ST_ILL1: begin
            cmd.op   = OP_ILL1;
            state_in = ST_BRANCH;
         end
         ST_BRANCH: begin
            dsel_in  = !status.first_on;
            state_in = status.bad ? ST_DONE : ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.op   = OP_DLOAD;
            step_in  = '0;
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.op  = OP_DSTEP;
            step_in = step_ff + 1'b1;
            if (step_ff == STW'(NUMW - 1))
               state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op   = OP_ROUND;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.op = OP_SAT;
            if (both_on && !dsel_ff) begin
               dsel_in  = 1'b1;
               state_in = ST_DLOAD;
            end else
               state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.op   = OP_EMIT;
               state_in = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         sel_ff   <= '0;
         part_ff  <= '0;
         dsel_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         part_ff  <= part_in;
         dsel_ff  <= dsel_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ----- src/sgr_projection_fit_top.sv -----
// After the last pixel of a unit the sequencer drains the pipeline, forms six wide
// products when both filters are on, runs the ill-posed test, then divides once per
// enabled coefficient unless ill-posed; the bit-serial divider sets the per-unit cost.
// Throughput: one pixel per cycle, but only while the sequencer is accumulating.
// Reset: synchronous, clears sums and count; both filters come up enabled.
// ----------------------------------------------------------------------------
// sgr_projection_fit_top
// Self-guided restoration projection fit: least-squares coefficients per unit.
// ----------------------------------------------------------------------------
module sgr_projection_fit_top #(
   parameter int RESTORE_FRAC_BITS = 4,
   parameter int PROJ_FRAC_BITS    = 7,
   parameter int MAX_PIXELS        = 1048576
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // source_sample, degraded_sample, filtered_a, filtered_b, zero pad
   input  logic [sgrpf_pkg::IN_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // coeff_first, coeff_second
   output logic [sgrpf_pkg::OUT_DATA_W-1:0]      rsp_tdata,
   // ill_posed
   output logic                                  rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic [sgrpf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic                                  csr_wdata
);
   import sgrpf_pkg::*;

   logic                       first_on_ff, second_on_ff;
   logic                       in_accept;
   cmd_type                    cmd;
   status_type                 status;
   logic signed [COEFF_W-1:0]  coeff_first, coeff_second;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_on_ff  <= 1'b1;
         second_on_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_ON:  first_on_ff  <= csr_wdata;
            CSR_SECOND_ON: second_on_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign in_accept = req_tvalid && req_tready;

   sgrpf_ctrl #(
      .PROJ_FRAC_BITS (PROJ_FRAC_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sgrpf_datapath #(
      .RESTORE_FRAC_BITS (RESTORE_FRAC_BITS),
      .PROJ_FRAC_BITS    (PROJ_FRAC_BITS),
      .MAX_PIXELS        (MAX_PIXELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .in_accept       (in_accept),
      .source_sample   (req_tdata[11:0]),
      .degraded_sample (req_tdata[23:12]),
      .filtered_a      ($signed(req_tdata[41:24])),
      .filtered_b      ($signed(req_tdata[59:42])),
      .first_on        (first_on_ff),
      .second_on       (second_on_ff),
      .cmd             (cmd),
      .status          (status),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .coeff_first     (coeff_first),
      .coeff_second    (coeff_second),
      .ill_posed       (rsp_tuser)
   );

   assign rsp_tdata = {coeff_second, coeff_first};

endmodule

// ----- test/sgrpf_checker.sv -----
// ----------------------------------------------------------------------------
// sgrpf_checker
// Watches the pixel, result and register ports of the projection fit block,
// recomputes each unit's coefficients with exact wide integers and compares
// every result word against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sgrpf_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic        csr_wdata,
   output int          errors,
   output int          pending
);
   import sgrpf_pkg::*;

   localparam int FRAC_IN    = 4;
   localparam int FRAC_OUT   = 7;
   localparam int PIX_LIMIT  = 1048576;

   typedef logic signed [191:0] wide_t;
   typedef struct packed {
      logic [31:0] coeff_first;
      logic [31:0] coeff_second;
      logic        ill_posed;
   } fit_t;

   logic              use_first, use_second;
   logic signed [63:0] acc_aa, acc_bb, acc_ab, acc_as, acc_bs;
   logic [20:0]       pix_seen;
   fit_t              fit_q[$];

   assign pending = fit_q.size();

   task automatic report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // magnitude * 2^FRAC_OUT / den, ties to even, clamped to signed 32 bits
   function automatic logic [31:0] scaled_div(input wide_t num, input wide_t den);
      logic        neg;
      logic [191:0] m, d, q, r, lim;
      neg = num < 0;
      m   = neg ? -num : num;
      m   = m << FRAC_OUT;
      d   = den;
      q   = m / d;
      r   = m % d;
      if ((r << 1) > d || ((r << 1) == d && q[0])) q = q + 1;
      lim = neg ? 192'h8000_0000 : 192'h7fff_ffff;
      if (q > lim) q = lim;
      return neg ? -q[31:0] : q[31:0];
   endfunction

   function automatic logic is_ill(input wide_t det, input logic [63:0] bound);
      wide_t b;
      b = {128'd0, bound};
      return det < 0 || det * 100000000 < b;
   endfunction

   function automatic fit_t solve_unit();
      fit_t  f;
      wide_t a, b, x, p, q, det;
      a = acc_aa; b = acc_bb; x = acc_ab; p = acc_as; q = acc_bs;
      f = '0;
      if (!use_first || !use_second) begin
         det = use_first ? a : b;
         f.ill_posed = is_ill(det, {43'd0, pix_seen});
         if (!f.ill_posed) begin
            if (use_first) f.coeff_first = scaled_div(p, det);
            else f.coeff_second = scaled_div(q, det);
         end
      end else begin
         det = a * b - x * x;
         f.ill_posed = is_ill(det, {43'd0, pix_seen} * {43'd0, pix_seen});
         if (!f.ill_posed) begin
            f.coeff_first  = scaled_div(b * p - x * q, det);
            f.coeff_second = scaled_div(a * q - x * p, det);
         end
      end
      return f;
   endfunction

   always @(posedge clock) begin
      fit_t got, want;
      logic signed [63:0] u, s, fa, fb;
      if (reset) begin
         use_first  <= 1'b1;
         use_second <= 1'b1;
         acc_aa = 0; acc_bb = 0; acc_ab = 0; acc_as = 0; acc_bs = 0;
         pix_seen = 0;
         fit_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser};
            if (fit_q.size() == 0) report("result word with nothing expected");
            else begin
               want = fit_q.pop_front();
               if (got.coeff_first != want.coeff_first)
                  report($sformatf("coeff_first %0d, want %0d",
                     $signed(got.coeff_first), $signed(want.coeff_first)));
               if (got.coeff_second != want.coeff_second)
                  report($sformatf("coeff_second %0d, want %0d",
                     $signed(got.coeff_second), $signed(want.coeff_second)));
               if (got.ill_posed != want.ill_posed)
                  report($sformatf("ill_posed %0b, want %0b",
                     got.ill_posed, want.ill_posed));
            end
         end
         if (req_tvalid && req_tready) begin
            u  = {52'd0, req_tdata[23:12]} << FRAC_IN;
            s  = ({52'd0, req_tdata[11:0]} << FRAC_IN) - u;
            fa = use_first  ? {{46{req_tdata[41]}}, req_tdata[41:24]} - u : 64'sd0;
            fb = use_second ? {{46{req_tdata[59]}}, req_tdata[59:42]} - u : 64'sd0;
            acc_aa += fa * fa;
            acc_bb += fb * fb;
            acc_ab += fa * fb;
            acc_as += fa * s;
            acc_bs += fb * s;
            if (pix_seen < PIX_LIMIT) pix_seen++;
            if (req_tlast) begin
               fit_q.push_back(solve_unit());
               acc_aa = 0; acc_bb = 0; acc_ab = 0; acc_as = 0; acc_bs = 0;
               pix_seen = 0;
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_FIRST_ON) use_first <= csr_wdata;
            else if (csr_index == CSR_SECOND_ON) use_second <= csr_wdata;
         end
      end
   end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Pixel-stream stimulus for the projection fit block: directed extreme units,
// then random units under every filter setting, with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb;
   import sgrpf_pkg::*;

   logic        clock, reset;
   logic [63:0] req_tdata;
   logic        req_tlast, req_tvalid, req_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser, rsp_tvalid, rsp_tready;
   logic        csr_we, csr_wdata;
   logic [CSR_IDX_W-1:0] csr_index;
   int          errors, pending;
   logic        hold_go;

   sgr_projection_fit_top uut (.*);

   sgrpf_checker chk (.*);

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // receiver: random stalls plus one long hold-off when asked
   initial begin
      int n;
      bit held;
      held = 1'b0;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_go && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            for (n = 0; n < 3000; n++) @(posedge clock);
         end
         n = pick_gap();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   task automatic send_pixel(input logic [11:0] src, input logic [11:0] deg,
                             input logic [17:0] fa, input logic [17:0] fb,
                             input logic last, input logic no_gap);
      int g;
      g = no_gap ? 0 : pick_gap();
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tdata  <= {4'd0, fb, fa, deg, src};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_and_write(input logic first_on, input logic second_on);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_FIRST_ON;
      csr_wdata <= first_on;
      @(posedge clock);
      csr_index <= CSR_SECOND_ON;
      csr_wdata <= second_on;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // filtered value near the degraded sample, with occasional full-range noise
   function automatic logic [17:0] near(input logic [11:0] deg, input int spread);
      int v;
      if ($urandom_range(0, 15) == 0) return 18'($urandom());
      v = {deg, 4'd0} + $urandom_range(0, 2 * spread) - spread;
      return 18'(v);
   endfunction

   task automatic random_unit(input int len);
      logic [11:0] src, deg;
      logic [17:0] fa, fb;
      int mode, sp;
      mode = $urandom_range(0, 9);
      sp   = $urandom_range(1, 4000);
      for (int i = 0; i < len; i++) begin
         deg = 12'($urandom());
         src = (mode == 0) ? 12'($urandom()) : 12'(deg + $urandom_range(0, 40) - 20);
         fa  = near(deg, sp);
         fb  = (mode == 1) ? fa : (mode == 2) ? {deg, 4'd0} : near(deg, sp);
         if (mode == 3) begin
            fa = 18'($urandom()); fb = 18'($urandom()); src = 12'($urandom());
         end
         send_pixel(src, deg, fa, fb, i == len - 1, 1'b0);
      end
   endtask

   int sent;

   initial begin
      reset      = 1'b1;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      req_tvalid = 1'b0;
      csr_we     = 1'b0;
      csr_index  = CSR_FIRST_ON;
      csr_wdata  = 1'b0;
      hold_go    = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single pixel of zeros: degenerate system
      send_pixel(12'd0, 12'd0, 18'd0, 18'd0, 1'b1, 1'b1);
      // field extremes
      send_pixel(12'hfff, 12'd0, 18'h1ffff, 18'h20000, 1'b0, 1'b0);
      send_pixel(12'd0, 12'hfff, 18'h20000, 18'h1ffff, 1'b0, 1'b1);
      send_pixel(12'hfff, 12'hfff, 18'h3ffff, 18'h00001, 1'b1, 1'b0);
      // identical filters: singular in the two-filter case
      send_pixel(12'h123, 12'h456, 18'h01000, 18'h01000, 1'b0, 1'b0);
      send_pixel(12'h800, 12'h7ff, 18'h02222, 18'h02222, 1'b1, 1'b0);
      // tiny filter term, large source error; the zero second filter term makes the two-filter system singular
      send_pixel(12'hfff, 12'h000, 18'h00001, 18'h00000, 1'b1, 1'b0);
      send_pixel(12'h000, 12'h100, 18'h01001, 18'h01002, 1'b0, 1'b0);
      send_pixel(12'h000, 12'h100, 18'h00fff, 18'h01000, 1'b1, 1'b0);
      drain_and_write(1'b0, 1'b1);
      send_pixel(12'hfff, 12'h000, 18'h00001, 18'h00003, 1'b1, 1'b0);
      send_pixel(12'h100, 12'h0ff, 18'h01000, 18'h20000, 1'b1, 1'b0);
      drain_and_write(1'b1, 1'b0);
      send_pixel(12'h000, 12'hfff, 18'h0fff1, 18'h00000, 1'b1, 1'b0);
      send_pixel(12'h100, 12'h0ff, 18'h1ffff, 18'h00000, 1'b1, 1'b0);
      drain_and_write(1'b0, 1'b0);
      send_pixel(12'h321, 12'h123, 18'h03000, 18'h02000, 1'b1, 1'b0);
      drain_and_write(1'b1, 1'b1);

      sent = 0;
      hold_go <= 1'b1;
      while (sent < 1030) begin
         int len;
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 10);
         random_unit(len);
         sent += len;
         case ((sent / 200) % 5)
            1: if (sent % 200 < 10) drain_and_write(1'b0, 1'b1);
            2: if (sent % 200 < 10) drain_and_write(1'b1, 1'b0);
            3: if (sent % 200 < 10) drain_and_write(1'b0, 1'b0);
            4: if (sent % 200 < 10) drain_and_write(1'b1, 1'b1);
            default: ;
         endcase
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (errors == 0 && pending == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #8000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
